// ----- rtl/core/aes128_cbc_pkcs7_cipher_defines.svh -----
// Assertion macros for the AES-128 CBC cipher block.
`ifndef AES128_CBC_PKCS7_CIPHER_DEFINES_SVH
`define AES128_CBC_PKCS7_CIPHER_DEFINES_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ----- rtl/core/acbc_pkg.sv -----
// ----------------------------------------------------------------------------
// acbc_pkg
// Shared types, constants and AES byte functions for the CBC cipher block.
// ----------------------------------------------------------------------------
package acbc_pkg;

  localparam int RoundKeyWords = 22;
  localparam int NumRounds     = 10;

  typedef enum logic [1:0] {
    CFG_KEY_HIGH = 2'd0,
    CFG_KEY_LOW  = 2'd1,
    CFG_MODE     = 2'd2
  } cfg_index_t;

  // controller -> datapath commands
  typedef struct packed {
    logic       load_in;     // latch input beat and do initial key add
    logic       load_pad;    // load full padding block for second result
    logic       round_step;  // run one round
    logic [3:0] round;       // round number being computed (1..10)
    logic       finish;      // capture result into output register
    logic       key_start;   // start key expansion
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic key_busy;
    logic need_pad;  // current item is full last encrypt block
  } dp_status_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h00;
    p = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ p;
      p = xtime(p);
    end
    return r;
  endfunction

  function automatic logic [7:0] ginv(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] p;
    logic [7:0] e;
    r = 8'h01;
    p = x;
    e = 8'd254;
    for (int i = 0; i < 8; i++) begin
      if (e[i]) r = gmul(r, p);
      p = gmul(p, p);
    end
    return r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] b;
    b = ginv(x);
    return b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] isbox_calc(input logic [7:0] s);
    return ginv(rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ 8'h05);
  endfunction

  // constant tables, folded at elaboration
  typedef logic [7:0] byte_tab_t [256];

  function automatic byte_tab_t make_sbox(input logic inv);
    byte_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = inv ? isbox_calc(8'(i)) : sbox_calc(8'(i));
    end
    return t;
  endfunction

  localparam byte_tab_t SBOX  = make_sbox(1'b0);
  localparam byte_tab_t ISBOX = make_sbox(1'b1);

endpackage

// ----- rtl/core/acbc_ctrl.sv -----
// ----------------------------------------------------------------------------
// acbc_ctrl
// Sequencer: item load, ten rounds, result hand-off, optional padding block.
// ----------------------------------------------------------------------------
`include "aes128_cbc_pkcs7_cipher_defines.svh"
module acbc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  acbc_pkg::dp_status_t status,
  output acbc_pkg::dp_cmd_t    cmd
);
  import acbc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ROUND = 4'b0010,
    S_OUT   = 4'b0100,
    S_PAD   = 4'b1000
  } state_t;

  state_t     state, state_next;
  logic [3:0] round, round_next;
  logic       out_full, out_full_next;
  logic       pad_pending, pad_pending_next;

  assign in_stall  = !(state == S_IDLE) || status.key_busy;
  assign out_valid = out_full;

  always_comb begin
    state_next       = state;
    round_next       = round;
    out_full_next    = out_full;
    pad_pending_next = pad_pending;
    cmd              = '0;
    cmd.round        = round;
    if (out_full && !out_stall) out_full_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load_in      = 1'b1;
          pad_pending_next = status.need_pad;
          round_next       = 4'd1;
          state_next       = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round_step = 1'b1;
        round_next     = round + 4'd1;
        if (round == 4'(NumRounds)) state_next = S_OUT;
      end
      S_OUT: begin
        // wait for the output register to free up
        if (!out_full || !out_stall) begin
          cmd.finish    = 1'b1;
          out_full_next = 1'b1;
          state_next    = pad_pending ? S_PAD : S_IDLE;
        end
      end
      S_PAD: begin
        cmd.load_pad     = 1'b1;
        pad_pending_next = 1'b0;
        round_next       = 4'd1;
        state_next       = S_ROUND;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      round       <= 4'd0;
      out_full    <= 1'b0;
      pad_pending <= 1'b0;
    end else begin
      state       <= state_next;
      round       <= round_next;
      out_full    <= out_full_next;
      pad_pending <= pad_pending_next;
    end
  end

  `ASSERT_IMPLIES(a_onehot, clk, rst, 1'b1, $onehot(state))
  `ASSERT_IMPLIES(a_no_accept_busy, clk, rst, state != S_IDLE, in_stall)
  `ASSERT_NEXT(a_finish_sets_out, clk, rst, cmd.finish, out_full)
  `ASSERT_IMPLIES(a_round_range, clk, rst, state == S_ROUND,
    round >= 4'd1 && round <= 4'(NumRounds))
endmodule

// ----- rtl/core/acbc_dp.sv -----
// ----------------------------------------------------------------------------
// acbc_dp
// Datapath: key expansion into round key memory, round state, chaining,
// padding build and padding check, output register.
// ----------------------------------------------------------------------------
module acbc_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic [63:0]          block_high,
  input  logic [63:0]          block_low,
  input  logic [4:0]           valid_bytes,
  input  logic                 last_block,
  input  acbc_pkg::dp_cmd_t    cmd,
  output acbc_pkg::dp_status_t status,
  output logic [63:0]          result_high,
  output logic [63:0]          result_low,
  output logic [4:0]           result_bytes,
  output logic                 result_last,
  output logic                 padding_error
);
  import acbc_pkg::*;

  // -------- configuration registers --------
  logic [63:0] key_high, key_low;
  logic        decrypt_mode;
  logic        key_dirty;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high     <= '0;
      key_low      <= '0;
      decrypt_mode <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_KEY_HIGH: key_high     <= cfg_data;
        CFG_KEY_LOW:  key_low      <= cfg_data;
        CFG_MODE:     decrypt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // -------- key expansion: one round key per cycle --------
  logic [127:0] kx;
  logic [3:0]   kx_cnt;
  logic [7:0]   rcon;
  logic         kx_busy;
  logic [127:0] rk_mem [11];
  logic [127:0] kx_next;
  logic [31:0]  kt;

  always_comb begin
    kt = {SBOX[kx[23:16]], SBOX[kx[15:8]], SBOX[kx[7:0]], SBOX[kx[31:24]]}
         ^ {rcon, 24'h0};
    kx_next[127:96] = kx[127:96] ^ kt;
    kx_next[95:64]  = kx[95:64] ^ kx_next[127:96];
    kx_next[63:32]  = kx[63:32] ^ kx_next[95:64];
    kx_next[31:0]   = kx[31:0] ^ kx_next[63:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_dirty <= 1'b1;
      kx_busy   <= 1'b0;
      kx_cnt    <= 4'd0;
      rcon      <= 8'h01;
    end else if (cfg_valid && (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW)) begin
      key_dirty <= 1'b1;
      kx_busy   <= 1'b0;
    end else if (key_dirty) begin
      key_dirty <= 1'b0;
      kx_busy   <= 1'b1;
      kx_cnt    <= 4'd0;
      rcon      <= 8'h01;
      kx        <= {key_high, key_low};
    end else if (kx_busy) begin
      rk_mem[kx_cnt] <= kx;
      kx             <= kx_next;
      rcon           <= xtime(rcon);
      kx_cnt         <= kx_cnt + 4'd1;
      if (kx_cnt == 4'(NumRounds)) kx_busy <= 1'b0;
    end
  end

  assign status.key_busy = kx_busy || key_dirty;

  // -------- round key read (registered) --------
  logic [127:0] rk;
  logic         mode_q;

  // -------- round state --------
  logic [127:0] st, chain, ct_in;
  logic         last_q, pad_q;
  logic [127:0] rk0, rk10;
  logic         status_pad_q;

  // input with PKCS7 padding applied
  logic [4:0]   vb;
  logic [127:0] padded;
  always_comb begin
    vb = (valid_bytes > 5'd16) ? 5'd16 : valid_bytes;
    padded = {block_high, block_low};
    if (last_block && vb < 5'd16 && !decrypt_mode) begin
      for (int i = 0; i < 16; i++) begin
        if (5'(i) >= vb) padded[127 - 8*i -: 8] = 8'(5'd16 - vb);
      end
    end
  end
  assign status.need_pad = !decrypt_mode && last_block && vb == 5'd16;

  // round functions
  function automatic logic [127:0] enc_round(input logic [127:0] s,
                                             input logic [127:0] k,
                                             input logic         final_rnd);
    logic [7:0]   b [16];
    logic [7:0]   t [16];
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = SBOX[s[127 - 8*i -: 8]];
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) t[r + 4*c] = b[r + 4*((c + r) & 3)];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[127 - 8*(r + 4*c) -: 8] = final_rnd ? t[r + 4*c] :
          (xtime(t[r + 4*c]) ^ xtime(t[((r+1)&3) + 4*c]) ^ t[((r+1)&3) + 4*c]
           ^ t[((r+2)&3) + 4*c] ^ t[((r+3)&3) + 4*c]);
    return o ^ k;
  endfunction

  function automatic logic [127:0] dec_round(input logic [127:0] s,
                                             input logic [127:0] k,
                                             input logic         final_rnd);
    logic [7:0]   b [16];
    logic [7:0]   t [16];
    logic [127:0] o;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        b[r + 4*c] = ISBOX[s[127 - 8*(r + 4*((c - r + 4) & 3)) -: 8]];
    for (int i = 0; i < 16; i++) t[i] = b[i] ^ k[127 - 8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[127 - 8*(r + 4*c) -: 8] = final_rnd ? t[r + 4*c] :
          (gmul(t[r + 4*c], 8'h0e) ^ gmul(t[((r+1)&3) + 4*c], 8'h0b)
           ^ gmul(t[((r+2)&3) + 4*c], 8'h0d) ^ gmul(t[((r+3)&3) + 4*c], 8'h09));
    return o;
  endfunction

  // round key read port: key for round r in encrypt is r, in decrypt 10-r
  logic [3:0] rd_addr;
  always_comb begin
    if (cmd.load_in || cmd.load_pad) rd_addr = 4'd1;
    else rd_addr = cmd.round + 4'd1;
    if ((cmd.load_in && decrypt_mode) || (!(cmd.load_in) && mode_q))
      rd_addr = 4'(NumRounds) - rd_addr;
  end
  always_ff @(posedge clk) begin
    rk <= rk_mem[rd_addr];
  end

  // first and last round keys feed the load step directly
  assign rk0  = rk_mem[4'd0];
  assign rk10 = rk_mem[4'(NumRounds)];

  always_ff @(posedge clk) begin
    if (rst) begin
      chain  <= '0;
      mode_q <= 1'b0;
      last_q <= 1'b0;
      pad_q  <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        mode_q <= decrypt_mode;
        last_q <= last_block;
        pad_q  <= 1'b0;
        ct_in  <= {block_high, block_low};
        if (decrypt_mode) st <= {block_high, block_low} ^ rk10;
        else st <= padded ^ chain ^ rk0;
      end else if (cmd.load_pad) begin
        pad_q <= 1'b1;
        st    <= {16{8'h10}} ^ chain ^ rk0;
      end else if (cmd.round_step) begin
        if (mode_q) st <= dec_round(st, rk, cmd.round == 4'(NumRounds));
        else st <= enc_round(st, rk, cmd.round == 4'(NumRounds));
      end
      if (cmd.finish) begin
        if (mode_q) chain <= (last_q) ? '0 : ct_in;
        else chain <= (last_q && !pad_q && !status_pad_q) ? '0 :
                      ((last_q && pad_q) ? '0 : st);
      end
    end
  end

  // remember whether this encrypt item spawns a padding block
  always_ff @(posedge clk) begin
    if (cmd.load_in) status_pad_q <= status.need_pad;
  end

  // -------- padding check and output register --------
  logic [127:0] pt;
  logic [7:0]   pad;
  logic         ok;
  always_comb begin
    pt  = st ^ chain;
    pad = pt[7:0];
    ok  = pad >= 8'd1 && pad <= 8'd16;
    for (int i = 0; i < 16; i++) begin
      if (8'(i) < pad && pt[8*i +: 8] != pad) ok = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (mode_q) begin
        {result_high, result_low} <= pt;
        result_last   <= last_q;
        result_bytes  <= (last_q) ? (ok ? 5'(8'd16 - pad) : 5'd0) : 5'd16;
        padding_error <= last_q && !ok;
      end else begin
        {result_high, result_low} <= st;
        result_bytes  <= 5'd16;
        result_last   <= last_q && (pad_q || !status_pad_q);
        padding_error <= 1'b0;
      end
    end
  end
endmodule

// ----- rtl/core/aes128_cbc_pkcs7_cipher.sv -----
// ----------------------------------------------------------------------------
// aes128_cbc_pkcs7_cipher
// AES-128 CBC (zero IV) with PKCS7 padding on encrypt and padding check on
// decrypt.
//
//  channel | signals                          | direction
//  in      | in_valid / in_stall + fields     | into block
//  out     | out_valid / out_stall + fields   | out of block
//  cfg     | cfg_valid / cfg_ready, index     | into block
//
// Each item is loaded with the initial key add, then runs ten rounds on one
// shared round unit, then is handed off to the output register; a full last
// encrypt block then runs a padding block the same way. After reset and each
// key write the key expansion runs with input stalled. The output register
// frees the round unit while a result waits; out_stall holds it.
// ----------------------------------------------------------------------------
module aes128_cbc_pkcs7_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  input  logic [4:0]  valid_bytes,
  input  logic        last_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_high,
  output logic [63:0] result_low,
  output logic [4:0]  result_bytes,
  output logic        result_last,
  output logic        padding_error
);
  import acbc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  acbc_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .cmd(cmd)
  );

  acbc_dp u_dp (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .block_high(block_high), .block_low(block_low),
    .valid_bytes(valid_bytes), .last_block(last_block),
    .cmd(cmd), .status(status),
    .result_high(result_high), .result_low(result_low),
    .result_bytes(result_bytes), .result_last(result_last),
    .padding_error(padding_error)
  );
endmodule

// ----- test/aes128_cbc_pkcs7_cipher_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aes128_cbc_pkcs7_cipher_tb
// Self-checking bench for the AES-128 CBC cipher with PKCS7 padding. A local
// AES model tracks key, mode and chaining value, queues the expected result
// beats for every accepted block beat and compares them in order with the
// output channel, under random idling on both sides and a long output hold.
// ----------------------------------------------------------------------------
module aes128_cbc_pkcs7_cipher_tb;
  import acbc_pkg::*;

  typedef logic [7:0] blk_t [16];

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  nbytes;
    logic        last;
    logic        err;
  } cipher_beat_t;

  // ---- AES byte arithmetic ----
  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return r;
  endfunction

  function automatic logic [7:0] gf_inv(logic [7:0] x);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h01;
    p = x;
    for (int i = 1; i < 8; i++) begin
      p = gf_mul(p, p);
      r = gf_mul(r, p);
    end
    return r;
  endfunction

  function automatic logic [7:0] rot8(logic [7:0] v, int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  logic [7:0] fwd_sub [256];
  logic [7:0] inv_sub [256];

  function automatic void split(logic [63:0] hi, logic [63:0] lo, ref blk_t b);
    for (int i = 0; i < 8; i++) begin
      b[i] = hi[63 - 8 * i -: 8];
      b[8 + i] = lo[63 - 8 * i -: 8];
    end
  endfunction

  function automatic logic [63:0] join8(blk_t b, int base);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < 8; i++) v = {v[55:0], b[base + i]};
    return v;
  endfunction

  // ---- scoreboard: cipher state and expected beats ----
  class cbc_scoreboard;
    logic [7:0]   rk [176];
    logic [63:0]  key_hi, key_lo;
    logic         decrypt;
    blk_t         chain;
    cipher_beat_t pending_beats [$];
    int           mismatches;

    function void expand();
      logic [7:0] t [4];
      logic [7:0] rc;
      logic [7:0] u;
      blk_t k;
      rc = 8'h01;
      split(key_hi, key_lo, k);
      for (int i = 0; i < 16; i++) rk[i] = k[i];
      for (int i = 16; i < 176; i += 4) begin
        for (int j = 0; j < 4; j++) t[j] = rk[i - 4 + j];
        if (i % 16 == 0) begin
          u = t[0];
          t[0] = fwd_sub[t[1]] ^ rc;
          t[1] = fwd_sub[t[2]];
          t[2] = fwd_sub[t[3]];
          t[3] = fwd_sub[u];
          rc = gf_mul(rc, 8'h02);
        end
        for (int j = 0; j < 4; j++) rk[i + j] = rk[i - 16 + j] ^ t[j];
      end
    endfunction

    function void clear_all();
      key_hi = '0;
      key_lo = '0;
      decrypt = 1'b0;
      foreach (chain[i]) chain[i] = 8'h00;
      expand();
    endfunction

    function void write_reg(cfg_index_t idx, logic [63:0] v);
      case (idx)
        CFG_KEY_HIGH: begin key_hi = v; expand(); end
        CFG_KEY_LOW:  begin key_lo = v; expand(); end
        CFG_MODE:     decrypt = v[0];
        default: ;
      endcase
    endfunction

    function void add_key(ref blk_t s, input int r);
      for (int i = 0; i < 16; i++) s[i] ^= rk[16 * r + i];
    endfunction

    function void rows(ref blk_t s, input bit inv);
      blk_t t;
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          t[r + 4 * c] = s[r + 4 * ((inv ? (c - r + 4) : (c + r)) & 3)];
      s = t;
    endfunction

    function void cols(ref blk_t s, input logic [7:0] m [4]);
      logic [7:0] a [4];
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) a[r] = s[4 * c + r];
        for (int r = 0; r < 4; r++)
          s[r + 4 * c] = gf_mul(a[0], m[(4 - r) & 3]) ^ gf_mul(a[1], m[(5 - r) & 3]) ^
                         gf_mul(a[2], m[(6 - r) & 3]) ^ gf_mul(a[3], m[(7 - r) & 3]);
      end
    endfunction

    function void encipher(ref blk_t s);
      logic [7:0] m [4];
      m = '{8'h02, 8'h03, 8'h01, 8'h01};
      add_key(s, 0);
      for (int r = 1; r <= 10; r++) begin
        for (int i = 0; i < 16; i++) s[i] = fwd_sub[s[i]];
        rows(s, 1'b0);
        if (r < 10) cols(s, m);
        add_key(s, r);
      end
    endfunction

    function void decipher(ref blk_t s);
      logic [7:0] m [4];
      m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
      add_key(s, 10);
      for (int r = 9; r >= 0; r--) begin
        rows(s, 1'b1);
        for (int i = 0; i < 16; i++) s[i] = inv_sub[s[i]];
        add_key(s, r);
        if (r > 0) cols(s, m);
      end
    endfunction

    function void push(blk_t b, logic [4:0] n, logic l, logic e);
      pending_beats.push_back({join8(b, 0), join8(b, 8), n, l, e});
    endfunction

    // accepted block beat -> expected result beats
    function void note_block(logic [63:0] hi, logic [63:0] lo, logic [4:0] vb,
                             logic last);
      blk_t b;
      blk_t p;
      int n;
      int pad;
      bit ok;
      n = (vb > 16) ? 16 : vb;
      split(hi, lo, b);
      if (!decrypt) begin
        if (last && n < 16)
          for (int i = n; i < 16; i++) b[i] = 8'(16 - n);
        for (int i = 0; i < 16; i++) b[i] ^= chain[i];
        encipher(b);
        chain = b;
        if (last && n == 16) begin
          push(b, 5'd16, 1'b0, 1'b0);
          for (int i = 0; i < 16; i++) p[i] = 8'h10 ^ chain[i];
          encipher(p);
          push(p, 5'd16, 1'b1, 1'b0);
        end else begin
          push(b, 5'd16, last, 1'b0);
        end
      end else begin
        decipher(b);
        for (int i = 0; i < 16; i++) b[i] ^= chain[i];
        split(hi, lo, chain);
        if (last) begin
          pad = b[15];
          ok = pad >= 1 && pad <= 16;
          if (ok)
            for (int i = 0; i < pad; i++) if (b[15 - i] != pad) ok = 0;
          push(b, ok ? 5'(16 - pad) : 5'd0, 1'b1, !ok);
        end else begin
          push(b, 5'd16, 1'b0, 1'b0);
        end
      end
      if (last) foreach (chain[i]) chain[i] = 8'h00;
    endfunction

    function void check_result(cipher_beat_t got);
      cipher_beat_t want;
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = pending_beats.pop_front();
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: exp %h_%h n=%0d l=%b e=%b got %h_%h n=%0d l=%b e=%b",
                   want.hi, want.lo, want.nbytes, want.last, want.err,
                   got.hi, got.lo, got.nbytes, got.last, got.err);
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid, in_stall;
  logic [63:0] block_high, block_low;
  logic [4:0]  valid_bytes;
  logic        last_block;
  logic        out_valid, out_stall;
  logic [63:0] result_high, result_low;
  logic [4:0]  result_bytes;
  logic        result_last, padding_error;

  cbc_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  int hold_cycles;

  aes128_cbc_pkcs7_cipher dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  // output side: random stall, optional long hold, check at rising edge
  initial begin
    out_stall = 1'b1;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_result({result_high, result_low, result_bytes, result_last,
                         padding_error});
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic write_reg(cfg_index_t idx, logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // valid stays high after the beat; the next call or drain() replaces it
  task automatic send_block(logic [63:0] hi, logic [63:0] lo, logic [4:0] vb,
                            logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    block_high  <= hi;
    block_low   <= lo;
    valid_bytes <= vb;
    last_block  <= last;
    do @(posedge clk); while (in_stall);
    sb.note_block(hi, lo, vb, last);
    @(negedge clk);
  endtask

  // wait out every pending beat plus pipeline drain
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_beats.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [4:0] rand_vb();
    return (($urandom_range(9) == 0) ? 5'($urandom_range(17, 31))
                                     : 5'($urandom_range(16)));
  endfunction

  // ciphertext message built from a plaintext run under the same key; valid unless corrupt flips its last block
  task automatic send_message(int len, bit corrupt);
    logic [63:0] hi [$];
    logic [63:0] lo [$];
    cipher_beat_t q [$];
    cbc_scoreboard tmp;
    tmp = new();
    tmp.key_hi = sb.key_hi;
    tmp.key_lo = sb.key_lo;
    tmp.rk = sb.rk;
    tmp.decrypt = 1'b0;
    foreach (tmp.chain[i]) tmp.chain[i] = 8'h00;
    for (int i = 0; i < len; i++) begin
      if (i == len - 1) tmp.note_block(rand64(), rand64(), rand_vb(), 1'b1);
      else tmp.note_block(rand64(), rand64(), rand_vb(), 1'b0);
    end
    q = tmp.pending_beats;
    foreach (q[i]) begin
      if (corrupt && i == q.size() - 1) q[i].lo ^= rand64() | 64'h1;
      send_block(q[i].hi, q[i].lo, rand_vb(), i == q.size() - 1);
    end
  endtask

  int phase;
  int count;

  initial begin
    sb = new();
    for (int i = 0; i < 256; i++) begin
      fwd_sub[i] = gf_inv(8'(i)) ^ rot8(gf_inv(8'(i)), 1) ^ rot8(gf_inv(8'(i)), 2) ^
                   rot8(gf_inv(8'(i)), 3) ^ rot8(gf_inv(8'(i)), 4) ^ 8'h63;
      inv_sub[fwd_sub[i]] = 8'(i);
    end
    sb.clear_all();
    rst = 1'b1;
    cfg_valid = 1'b0; cfg_index = CFG_KEY_HIGH; cfg_data = '0;
    in_valid = 1'b0; block_high = '0; block_low = '0; valid_bytes = 5'd16;
    last_block = 1'b0;
    send_idle_pct = 0; recv_idle_pct = 0; hold_cycles = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: zero key, field extremes, valid counts 0 to 16 in steps of four and above 16
    send_block('0, '0, 5'd16, 1'b0);
    send_block('1, '1, 5'd0, 1'b1);
    send_block('1, '0, 5'd16, 1'b1);
    send_block('0, '1, 5'd31, 1'b1);
    for (int v = 0; v <= 16; v += 4) send_block(rand64(), rand64(), 5'(v), 1'b1);
    send_block(rand64(), rand64(), 5'd17, 1'b1);
    drain();
    write_reg(CFG_KEY_HIGH, 64'h2b7e151628aed2a6);
    write_reg(CFG_KEY_LOW, 64'habf7158809cf4f3c);
    send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1'b0);
    send_block(rand64(), rand64(), 5'd5, 1'b1);
    drain();
    write_reg(CFG_MODE, 64'h1);
    send_message(2, 1'b0);
    send_message(1, 1'b1);
    send_block('1, '1, 5'd0, 1'b1);
    send_block('0, '0, 5'd16, 1'b1);
    drain();
    write_reg(CFG_KEY_HIGH, '1);
    write_reg(CFG_KEY_LOW, '1);
    write_reg(CFG_MODE, 64'h0);
    // long output hold while input keeps coming
    hold_cycles = 300;
    for (int i = 0; i < 8; i++) send_block(rand64(), rand64(), rand_vb(), i == 7);
    drain();

    // random phases: idle mixes, key and mode changes between phases
    count = 0;
    for (phase = 0; phase < 12; phase++) begin
      send_idle_pct = (phase < 4) ? 12 : (phase < 8) ? 73 : 0;
      recv_idle_pct = (phase < 4) ? 73 : (phase < 8) ? 12 : 0;
      if ($urandom_range(1)) write_reg(CFG_KEY_HIGH, rand64());
      if ($urandom_range(1)) write_reg(CFG_KEY_LOW, rand64());
      write_reg(CFG_MODE, 64'(phase & 1) | (rand64() & ~64'h1));
      while (count < (phase + 1) * 115) begin
        if (sb.decrypt && $urandom_range(9) < 7) begin
          send_message($urandom_range(1, 4), $urandom_range(4) == 0);
          count += 3;
        end else begin
          send_block(rand64(), rand64(), rand_vb(), $urandom_range(3) == 0);
          count++;
        end
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
